// File: rtl/core/utf8_to_utf16_validating_decoder_macros.svh
// Assertion macros shared by the decoder checker.
// Each macro expands to one labeled concurrent assertion reporting by $error.
`ifndef UTF8_TO_UTF16_VALIDATING_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_VALIDATING_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U8U16_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("u8u16 checker: same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define U8U16_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("u8u16 checker: next-cycle implication failed");

`endif

// File: rtl/core/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

    // Error codes carried on error beats
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_LEAD  = 3'd1,
        ERR_TRUNCATED = 3'd2,
        ERR_BAD_CONT  = 3'd3,
        ERR_OVERLONG  = 3'd4,
        ERR_SCALAR    = 3'd5
    } err_code_t;

    // One result beat
    typedef struct packed {
        logic [15:0] code_unit;
        err_code_t   error_code;
        logic [31:0] error_offset;
        logic        string_done;
        logic        run_last;
    } item_t;

    // Results produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        item_t      first;
        item_t      second;
    } step_t;

    // Result queue depth
    localparam int QDEPTH = 4;

    // Scalar limits
    localparam logic [20:0] SCALAR_MAX  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] MIN_LEN2    = 21'h000080;
    localparam logic [20:0] MIN_LEN3    = 21'h000800;
    localparam logic [15:0] HIGH_SURR   = 16'hD800;
    localparam logic [15:0] LOW_SURR    = 16'hDC00;

    // Lead byte bounds
    localparam logic [7:0] LEAD_MIN     = 8'hC2;
    localparam logic [7:0] LEAD_MAX     = 8'hF4;
    localparam logic [7:0] LEAD2_MAX    = 8'hDF;
    localparam logic [7:0] LEAD3_MAX    = 8'hEF;

    // Sequence lengths
    localparam logic [2:0] LEN_IDLE     = 3'd0;
    localparam logic [2:0] LEN_TWO      = 3'd2;
    localparam logic [2:0] LEN_THREE    = 3'd3;
    localparam logic [2:0] LEN_FOUR     = 3'd4;

endpackage

// File: rtl/core/u8u16_channels.sv
// Valid/ready channel interfaces for the decoder: UTF-8 byte input and
// UTF-16 result output. No dependencies.
`timescale 1ns / 1ps

interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [2:0]  error_code;
    logic [31:0] error_offset;
    logic        string_done;
    logic        run_last;

    modport source (output valid, output code_unit, output error_code,
                    output error_offset, output string_done, output run_last,
                    input ready);
    modport sink   (input valid, input code_unit, input error_code,
                    input error_offset, input string_done, input run_last,
                    output ready);
endinterface

// File: rtl/core/utf8_to_utf16_validating_decoder.sv
// Strict UTF-8 to UTF-16 decoder. An accepted beat passes the input register, then
// the result queue, before its first result shows. Throughput: one byte per cycle
// while the queue has room for two beats; a four-byte scalar emits two units, and
// the single output port then sets the pace at one unit per cycle.
// Reset (rst_n low, asynchronous) empties both stages and returns the decoder
// to the start of a string with offset zero.
`timescale 1ns / 1ps

module utf8_to_utf16_validating_decoder #(
    parameter int OFFSET_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    u8u16_in_if.sink           utf8,
    u8u16_out_if.source        utf16
);

    localparam int QD = u8u16_pkg::QDEPTH;
    localparam int PW = $clog2(u8u16_pkg::QDEPTH);
    localparam int CW = $clog2(u8u16_pkg::QDEPTH + 1);

    // Input register
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    // Result queue
    u8u16_pkg::item_t q_mem [QD];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;

    u8u16_pkg::step_t step;
    logic             room;
    logic             advance;
    logic             pop;
    logic [1:0]       push;
    u8u16_pkg::item_t head;

    // Room for the two beats a byte can produce
    assign room       = (count_reg <= CW'(QD - 2));
    assign advance    = valid_reg && room;
    assign utf8.ready = !valid_reg || room;
    assign pop        = utf16.valid && utf16.ready;
    assign push       = advance ? step.count : 2'd0;

    u8u16_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .in_byte    (byte_reg),
        .string_end (end_reg),
        .step       (step)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (utf8.ready) begin
            valid_reg <= utf8.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (utf8.valid && utf8.ready) begin
            byte_reg <= utf8.in_byte;
            end_reg  <= utf8.string_end;
        end
    end

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push != 2'd0) begin
            q_mem[wr_ptr_reg] <= step.first;
        end
        if (push == 2'd2) begin
            q_mem[wr_ptr_reg + PW'(1)] <= step.second;
        end
    end

    // Output beat
    assign head               = q_mem[rd_ptr_reg];
    assign utf16.valid        = (count_reg != '0);
    assign utf16.code_unit    = head.code_unit;
    assign utf16.error_code   = head.error_code;
    assign utf16.error_offset = head.error_offset;
    assign utf16.string_done  = head.string_done;
    assign utf16.run_last     = head.run_last;

endmodule

// File: rtl/core/u8u16_core.sv
// Per-byte UTF-8 decode step: sequence state registers and the single-pass
// decode logic producing up to two result beats. Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic                string_end,
    output u8u16_pkg::step_t    step
);

    localparam int OB  = OFFSET_BITS;
    localparam int OBP = OFFSET_BITS + 1;

    // Sequence state
    logic [OB-1:0] byte_offset_reg, byte_offset_next;
    logic [OB-1:0] seq_start_reg,   seq_start_next;
    logic [20:0]   accum_reg,       accum_next;
    logic [2:0]    seq_len_reg,     seq_len_next;
    logic [2:0]    taken_reg,       taken_next;
    logic          bad_pend_reg,    bad_pend_next;
    logic [1:0]    bad_idx_reg,     bad_idx_next;
    logic          drop_reg,        drop_next;

    logic [OB-1:0]          err_off;
    logic [OBP-1:0]         cont_sum;
    logic [31:0]            err_off32;
    u8u16_pkg::err_code_t   err;
    logic [20:0]            minimum;
    logic [20:0]            supp;
    logic [1:0]             n_units;
    logic [15:0]            unit0;
    logic [15:0]            unit1;

    // Clamp reported offset to the 32-bit port
    if (OB > 32) begin : g_clamp
        assign err_off32 = (|err_off[OB-1:32]) ? 32'hFFFF_FFFF : err_off[31:0];
    end else begin : g_extend
        assign err_off32 = 32'(err_off);
    end

    // Decode step and next state
    always_comb
    begin
        byte_offset_next = byte_offset_reg;
        seq_start_next   = seq_start_reg;
        accum_next       = accum_reg;
        seq_len_next     = seq_len_reg;
        taken_next       = taken_reg;
        bad_pend_next    = bad_pend_reg;
        bad_idx_next     = bad_idx_reg;
        drop_next        = drop_reg;
        err              = u8u16_pkg::ERR_NONE;
        err_off          = '0;
        n_units          = 2'd0;
        unit0            = '0;
        unit1            = '0;
        minimum          = u8u16_pkg::SUPP_BASE;
        supp             = '0;
        cont_sum         = '0;

        if (drop_reg) begin
            // rest of a failed string: nothing out
        end else if (seq_len_reg == u8u16_pkg::LEN_IDLE) begin
            if (in_byte[7] == 1'b0) begin
                n_units = 2'd1;
                unit0   = 16'(in_byte);
            end else if (in_byte inside {[u8u16_pkg::LEAD_MIN:u8u16_pkg::LEAD_MAX]}) begin
                if (in_byte <= u8u16_pkg::LEAD2_MAX) begin
                    seq_len_next = u8u16_pkg::LEN_TWO;
                    accum_next   = 21'(in_byte[4:0]);
                end else if (in_byte <= u8u16_pkg::LEAD3_MAX) begin
                    seq_len_next = u8u16_pkg::LEN_THREE;
                    accum_next   = 21'(in_byte[3:0]);
                end else begin
                    seq_len_next = u8u16_pkg::LEN_FOUR;
                    accum_next   = 21'(in_byte[2:0]);
                end
                seq_start_next = byte_offset_reg;
                taken_next     = 3'd1;
                if (string_end) begin
                    err     = u8u16_pkg::ERR_TRUNCATED;
                    err_off = byte_offset_reg;
                end
            end else begin
                err     = u8u16_pkg::ERR_BAD_LEAD;
                err_off = byte_offset_reg;
            end
        end else begin
            // continuation byte: remember the first bad one
            if (in_byte[7:6] != 2'b10 && !bad_pend_reg) begin
                bad_pend_next = 1'b1;
                bad_idx_next  = taken_reg[1:0];
            end
            accum_next = {accum_reg[14:0], in_byte[5:0]};
            taken_next = taken_reg + 3'd1;
            case (seq_len_reg)
                u8u16_pkg::LEN_TWO:   minimum = u8u16_pkg::MIN_LEN2;
                u8u16_pkg::LEN_THREE: minimum = u8u16_pkg::MIN_LEN3;
                default:              minimum = u8u16_pkg::SUPP_BASE;
            endcase
            cont_sum = {1'b0, seq_start_reg} + OBP'(bad_idx_next);
            supp     = accum_next - u8u16_pkg::SUPP_BASE;
            if (taken_next >= seq_len_reg) begin
                if (bad_pend_next) begin
                    err     = u8u16_pkg::ERR_BAD_CONT;
                    err_off = cont_sum[OB] ? '1 : cont_sum[OB-1:0];
                end else if (accum_next < minimum) begin
                    err     = u8u16_pkg::ERR_OVERLONG;
                    err_off = seq_start_reg;
                end else if (accum_next > u8u16_pkg::SCALAR_MAX ||
                             (accum_next >= u8u16_pkg::SURR_LO &&
                              accum_next <= u8u16_pkg::SURR_HI)) begin
                    err     = u8u16_pkg::ERR_SCALAR;
                    err_off = seq_start_reg;
                end else if (accum_next <= u8u16_pkg::BMP_MAX) begin
                    n_units = 2'd1;
                    unit0   = accum_next[15:0];
                end else begin
                    n_units = 2'd2;
                    unit0   = u8u16_pkg::HIGH_SURR | 16'(supp[19:10]);
                    unit1   = u8u16_pkg::LOW_SURR | 16'(supp[9:0]);
                end
                // sequence complete
                seq_start_next = '0;
                accum_next     = '0;
                seq_len_next   = u8u16_pkg::LEN_IDLE;
                taken_next     = '0;
                bad_pend_next  = 1'b0;
                bad_idx_next   = '0;
            end else if (string_end) begin
                err     = u8u16_pkg::ERR_TRUNCATED;
                err_off = seq_start_reg;
            end
        end

        // an error ends the sequence and drops the rest of the string
        if (err != u8u16_pkg::ERR_NONE) begin
            n_units        = 2'd1;
            seq_start_next = '0;
            accum_next     = '0;
            seq_len_next   = u8u16_pkg::LEN_IDLE;
            taken_next     = '0;
            bad_pend_next  = 1'b0;
            bad_idx_next   = '0;
            drop_next      = 1'b1;
        end

        // offset: saturating count, cleared at string end with all state
        if (string_end) begin
            byte_offset_next = '0;
            seq_start_next   = '0;
            accum_next       = '0;
            seq_len_next     = u8u16_pkg::LEN_IDLE;
            taken_next       = '0;
            bad_pend_next    = 1'b0;
            bad_idx_next     = '0;
            drop_next        = 1'b0;
        end else if (byte_offset_reg != '1) begin
            byte_offset_next = byte_offset_reg + OB'(1);
        end
    end

    // Result beats
    always_comb
    begin
        step.count = n_units;
        if (err != u8u16_pkg::ERR_NONE) begin
            step.first.code_unit    = '0;
            step.first.error_code   = err;
            step.first.error_offset = err_off32;
            step.first.string_done  = 1'b1;
            step.first.run_last     = 1'b1;
        end else begin
            step.first.code_unit    = unit0;
            step.first.error_code   = u8u16_pkg::ERR_NONE;
            step.first.error_offset = '0;
            step.first.string_done  = string_end && (n_units == 2'd1);
            step.first.run_last     = (n_units == 2'd1);
        end
        step.second.code_unit    = unit1;
        step.second.error_code   = u8u16_pkg::ERR_NONE;
        step.second.error_offset = '0;
        step.second.string_done  = string_end;
        step.second.run_last     = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_offset_reg <= '0;
            seq_start_reg   <= '0;
            accum_reg       <= '0;
            seq_len_reg     <= u8u16_pkg::LEN_IDLE;
            taken_reg       <= '0;
            bad_pend_reg    <= 1'b0;
            bad_idx_reg     <= '0;
            drop_reg        <= 1'b0;
        end else if (fire) begin
            byte_offset_reg <= byte_offset_next;
            seq_start_reg   <= seq_start_next;
            accum_reg       <= accum_next;
            seq_len_reg     <= seq_len_next;
            taken_reg       <= taken_next;
            bad_pend_reg    <= bad_pend_next;
            bad_idx_reg     <= bad_idx_next;
            drop_reg        <= drop_next;
        end
    end

endmodule

// File: rtl/core/u8u16_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on u8u16_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_to_utf16_validating_decoder_macros.svh"

module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] code_unit,
    input logic [2:0]  error_code,
    input logic [31:0] error_offset,
    input logic        string_done,
    input logic        run_last
);

    // A stalled result beat stays offered
    `U8U16_ASSERT_NXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)

    // An error beat closes its byte's run and its string, with no code unit
    `U8U16_ASSERT_IMP(a_err_closes, clk, rst_n, out_valid && error_code != u8u16_pkg::ERR_NONE, string_done && run_last && code_unit == 16'h0000)

    // Code unit beats report no offset
    `U8U16_ASSERT_IMP(a_unit_no_off, clk, rst_n, out_valid && error_code == u8u16_pkg::ERR_NONE, error_offset == 32'h0)

    // The end of a string is also the end of its byte's run
    `U8U16_ASSERT_IMP(a_done_last, clk, rst_n, out_valid && string_done, run_last)

    // Only a high surrogate is followed by more units of the same byte
    `U8U16_ASSERT_IMP(a_pair_high, clk, rst_n, out_valid && !run_last, code_unit[15:10] == 6'b110110)

endmodule

bind utf8_to_utf16_validating_decoder u8u16_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (utf16.valid),
    .out_ready    (utf16.ready),
    .code_unit    (utf16.code_unit),
    .error_code   (utf16.error_code),
    .error_offset (utf16.error_offset),
    .string_done  (utf16.string_done),
    .run_last     (utf16.run_last)
);

// File: dv/utf8_to_utf16_validating_decoder_tb.sv
// Self-checking testbench for the strict UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg, the u8u16 channel interfaces and the decoder RTL;
// a scoreboard class decodes each accepted byte and checks every result beat.
`timescale 1ns / 1ps

module utf8_to_utf16_validating_decoder_tb;

    localparam int STRING_TARGET = 1325;     // random bytes to send
    localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
    localparam int CYCLE_LIMIT   = 200000;   // watchdog
    localparam int PRINT_CAP     = 40;       // mismatch lines printed at most

    // Decodes accepted bytes into expected UTF-16 beats and checks results
    class utf16_scoreboard;
        u8u16_pkg::item_t expected_units[$];
        int               errors;
        // decoder state, mirrors the block
        logic [31:0]      byte_off;
        logic [31:0]      seq_start;
        logic [20:0]      accum;
        logic [2:0]       seq_len;
        logic [2:0]       taken;
        logic             bad_pend;
        logic [1:0]       bad_idx;
        logic             dropping;

        function new();
            errors   = 0;
            byte_off = '0;
            dropping = 1'b0;
            clear_seq();
        endfunction

        function void clear_seq();
            seq_start = '0;
            accum     = '0;
            seq_len   = u8u16_pkg::LEN_IDLE;
            taken     = '0;
            bad_pend  = 1'b0;
            bad_idx   = '0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void add_unit(logic [15:0] unit, logic done, logic last);
            u8u16_pkg::item_t it;
            it.code_unit    = unit;
            it.error_code   = u8u16_pkg::ERR_NONE;
            it.error_offset = '0;
            it.string_done  = done;
            it.run_last     = last;
            expected_units  = {expected_units, it};
        endfunction

        // offset plus index, stuck at all ones
        function logic [31:0] offset_add(logic [31:0] a, logic [1:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {31'd0, b};
            return s[32] ? '1 : s[31:0];
        endfunction

        // One accepted byte: update the decoder and queue what it emits
        function void note_byte(logic [7:0] b, logic last);
            u8u16_pkg::err_code_t err;
            logic [31:0]          err_off;
            logic [20:0]          cp;
            logic [20:0]          minimum;
            logic [20:0]          rel;
            u8u16_pkg::item_t     fail_beat;
            err     = u8u16_pkg::ERR_NONE;
            err_off = '0;
            if (dropping)
            begin
                // rest of a failed string: silent
            end
            else if (seq_len == u8u16_pkg::LEN_IDLE)
            begin
                if (!b[7])
                begin
                    add_unit({8'h00, b}, last, 1'b1);
                end
                else if (b >= u8u16_pkg::LEAD_MIN && b <= u8u16_pkg::LEAD_MAX)
                begin
                    seq_len   = (b <= u8u16_pkg::LEAD2_MAX) ? u8u16_pkg::LEN_TWO :
                                (b <= u8u16_pkg::LEAD3_MAX) ? u8u16_pkg::LEN_THREE :
                                                              u8u16_pkg::LEN_FOUR;
                    accum     = {13'd0, b} &
                                ((seq_len == u8u16_pkg::LEN_TWO)   ? 21'h1f :
                                 (seq_len == u8u16_pkg::LEN_THREE) ? 21'h0f : 21'h07);
                    seq_start = byte_off;
                    taken     = 3'd1;
                    if (last)
                    begin
                        err     = u8u16_pkg::ERR_TRUNCATED;
                        err_off = byte_off;
                    end
                end
                else
                begin
                    err     = u8u16_pkg::ERR_BAD_LEAD;
                    err_off = byte_off;
                end
            end
            else
            begin
                // first non-continuation byte is remembered, not reported yet
                if (b[7:6] != 2'b10 && !bad_pend)
                begin
                    bad_pend = 1'b1;
                    bad_idx  = taken[1:0];
                end
                accum = {accum[14:0], b[5:0]};
                taken = taken + 3'd1;
                if (taken >= seq_len)
                begin
                    cp      = accum;
                    minimum = (seq_len == u8u16_pkg::LEN_TWO)   ? u8u16_pkg::MIN_LEN2 :
                              (seq_len == u8u16_pkg::LEN_THREE) ? u8u16_pkg::MIN_LEN3 :
                                                                  u8u16_pkg::SUPP_BASE;
                    if (bad_pend)
                    begin
                        err     = u8u16_pkg::ERR_BAD_CONT;
                        err_off = offset_add(seq_start, bad_idx);
                    end
                    else if (cp < minimum)
                    begin
                        err     = u8u16_pkg::ERR_OVERLONG;
                        err_off = seq_start;
                    end
                    else if (cp > u8u16_pkg::SCALAR_MAX ||
                             (cp >= u8u16_pkg::SURR_LO && cp <= u8u16_pkg::SURR_HI))
                    begin
                        err     = u8u16_pkg::ERR_SCALAR;
                        err_off = seq_start;
                    end
                    else if (cp <= u8u16_pkg::BMP_MAX)
                    begin
                        add_unit(cp[15:0], last, 1'b1);
                    end
                    else
                    begin
                        rel = cp - u8u16_pkg::SUPP_BASE;
                        add_unit(u8u16_pkg::HIGH_SURR + {6'd0, rel[19:10]}, 1'b0, 1'b0);
                        add_unit(u8u16_pkg::LOW_SURR + {6'd0, rel[9:0]}, last, 1'b1);
                    end
                    if (err == u8u16_pkg::ERR_NONE)
                        clear_seq();
                end
                else if (last)
                begin
                    err     = u8u16_pkg::ERR_TRUNCATED;
                    err_off = seq_start;
                end
            end

            // error beat closes the string
            if (err != u8u16_pkg::ERR_NONE)
            begin
                fail_beat.code_unit    = '0;
                fail_beat.error_code   = err;
                fail_beat.error_offset = err_off;
                fail_beat.string_done  = 1'b1;
                fail_beat.run_last     = 1'b1;
                expected_units         = {expected_units, fail_beat};
                clear_seq();
                dropping = 1'b1;
            end

            if (last)
            begin
                byte_off = '0;
                dropping = 1'b0;
                clear_seq();
            end
            else if (byte_off != '1)
            begin
                byte_off = byte_off + 32'd1;
            end
        endfunction

        // One accepted result beat against the oldest expectation
        task check_unit(u8u16_pkg::item_t got);
            u8u16_pkg::item_t exp;
            if (expected_units.size() == 0)
            begin
                report($sformatf("unexpected beat unit=%h err=%0d off=%0d",
                                 got.code_unit, got.error_code, got.error_offset));
                return;
            end
            exp = expected_units.pop_front();
            if (got.code_unit !== exp.code_unit)
                report($sformatf("code_unit %h, expected %h", got.code_unit, exp.code_unit));
            if (got.error_code !== exp.error_code)
                report($sformatf("error_code %0d, expected %0d",
                                 got.error_code, exp.error_code));
            if (got.error_offset !== exp.error_offset)
                report($sformatf("error_offset %0d, expected %0d",
                                 got.error_offset, exp.error_offset));
            if (got.string_done !== exp.string_done)
                report($sformatf("string_done %b, expected %b",
                                 got.string_done, exp.string_done));
            if (got.run_last !== exp.run_last)
                report($sformatf("run_last %b, expected %b", got.run_last, exp.run_last));
        endtask

        task finish_check();
            if (expected_units.size() != 0)
                report($sformatf("%0d expected beats never arrived", expected_units.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    u8u16_in_if  utf8_bus ();
    u8u16_out_if utf16_bus ();

    utf8_to_utf16_validating_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8_bus),
        .utf16 (utf16_bus)
    );

    utf16_scoreboard sb;
    logic [7:0]      string_bytes[$];
    int              burst_left;
    int              bytes_sent;
    bit              hold_request;
    int unsigned     cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Result monitor: values read at the edge are the pre-edge values
    always @(posedge clk)
    begin
        u8u16_pkg::item_t got;
        if (rst_n && utf16_bus.valid && utf16_bus.ready)
        begin
            got.code_unit    = utf16_bus.code_unit;
            got.error_code   = u8u16_pkg::err_code_t'(utf16_bus.error_code);
            got.error_offset = utf16_bus.error_offset;
            got.string_done  = utf16_bus.string_done;
            got.run_last     = utf16_bus.run_last;
            sb.check_unit(got);
        end
    end

    // Receiver: stall patterns in phases, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int phase_left;
        int mode;
        int period;
        int tick;
        hold_left  = 0;
        phase_left = 0;
        mode       = 0;
        period     = 2;
        tick       = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                utf16_bus.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                utf16_bus.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = $urandom_range(3, 0);
                    phase_left = $urandom_range(150, 20);
                    period     = $urandom_range(7, 2);
                end
                phase_left--;
                tick++;
                case (mode)
                    0: utf16_bus.ready <= 1'b1;
                    1: utf16_bus.ready <= (tick % period) != 0;
                    2: utf16_bus.ready <= (tick % period) < 2;
                    default: utf16_bus.ready <= ($urandom_range(3, 0) != 0);
                endcase
            end
        end
    end

    // Offer one byte; bursts of random length separated by idle gaps
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(8, 1);
            utf8_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(24, 1);
        end
        utf8_bus.valid      <= 1'b1;
        utf8_bus.in_byte    <= b;
        utf8_bus.string_end <= last;
        do
            @(posedge clk);
        while (!utf8_bus.ready);
        sb.note_byte(b, last);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic drive_string();
        for (int i = 0; i < string_bytes.size(); i++)
            push_byte(string_bytes[i], i == string_bytes.size() - 1);
    endtask

    // Sender stops until every queued beat has come out
    task automatic drain_results();
        utf8_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.expected_units.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [20:0] valid_scalar(int n);
        logic [20:0] cp;
        case (n)
            1: cp = 21'($urandom_range(21'h7F, 0));
            2: cp = 21'($urandom_range(21'h7FF, 21'h80));
            3:
            begin
                cp = 21'($urandom_range(21'hFFFF, 21'h800));
                if (cp >= u8u16_pkg::SURR_LO && cp <= u8u16_pkg::SURR_HI)
                    cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
        return cp;
    endfunction

    // Append one encoded piece to the string; returns 1 if it ends the string
    function automatic bit add_piece();
        logic [7:0]  seq[4];
        logic [20:0] cp;
        int          n;
        int          keep;
        int          pick;
        bit          stop;
        pick = $urandom_range(99, 0);
        stop = 1'b0;
        keep = 0;
        if (pick < 30)
            n = 1;
        else if (pick < 50)
            n = 2;
        else if (pick < 70)
            n = 3;
        else
            n = 4;
        cp = valid_scalar(n);
        if (pick >= 85)
        begin
            case ($urandom_range(6, 0))
                0:
                begin  // any byte at all
                    n  = 1;
                    cp = 21'($urandom_range(255, 0));
                end
                1:
                begin  // overlong
                    n  = $urandom_range(4, 2);
                    cp = 21'((n == 2) ? $urandom_range(21'h7F, 0) :
                             (n == 3) ? $urandom_range(21'h7FF, 0) :
                                        $urandom_range(21'hFFFF, 0));
                end
                2:
                begin  // surrogate
                    n  = 3;
                    cp = 21'($urandom_range(u8u16_pkg::SURR_HI, u8u16_pkg::SURR_LO));
                end
                3:
                begin  // beyond the last scalar
                    n  = 4;
                    cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
                end
                4:
                begin  // one continuation byte replaced
                    n    = $urandom_range(4, 2);
                    cp   = valid_scalar(n);
                    keep = $urandom_range(n - 1, 1);
                end
                5:
                begin  // string ends inside the sequence
                    n    = $urandom_range(4, 2);
                    cp   = valid_scalar(n);
                    stop = 1'b1;
                end
                default:
                begin  // stray continuation byte
                    n  = 1;
                    cp = 21'($urandom_range(8'hBF, 8'h80));
                end
            endcase
        end
        case (n)
            1: seq[0] = cp[7:0];
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        if (keep != 0)
            seq[keep] = 8'($urandom_range(255, 0));
        if (stop)
        begin
            n = $urandom_range(n - 1, 1);
            if (n > 1 && $urandom_range(1, 0))
                seq[n - 1] = 8'($urandom_range(255, 0));
        end
        for (int i = 0; i < n; i++)
            string_bytes = {string_bytes, seq[i]};
        return stop;
    endfunction

    // Stimulus and end of run
    initial
    begin
        int  pieces;
        bit  paused;
        bit  hold_asked;
        sb           = new();
        burst_left   = 0;
        bytes_sent   = 0;
        hold_request = 1'b0;
        paused       = 1'b0;
        hold_asked   = 1'b0;
        rst_n               <= 1'b0;
        utf8_bus.valid      <= 1'b0;
        utf8_bus.in_byte    <= 8'h00;
        utf8_bus.string_end <= 1'b0;
        utf16_bus.ready     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest ASCII, smallest two-byte, largest scalar
        string_bytes = '{8'h00, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        drive_string();
        // bad leads at both ends of the range; byte after the error is dropped
        string_bytes = '{8'hFF};
        drive_string();
        string_bytes = '{8'h80, 8'h41};
        drive_string();
        // truncation wins over a bad continuation in the last byte
        string_bytes = '{8'hE0, 8'h41};
        drive_string();
        // bad continuation reported at its own offset
        string_bytes = '{8'hE1, 8'h41, 8'h80};
        drive_string();
        // overlong, surrogate, beyond the last scalar
        string_bytes = '{8'hE0, 8'h80, 8'h80};
        drive_string();
        string_bytes = '{8'hED, 8'hA0, 8'h80};
        drive_string();
        string_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        drive_string();

        // random strings, mostly well formed
        while (bytes_sent < STRING_TARGET + 25)
        begin
            string_bytes.delete();
            pieces = $urandom_range(8, 1);
            for (int k = 0; k < pieces; k++)
                if (add_piece())
                    break;
            drive_string();
            if (!hold_asked && bytes_sent >= 500)
            begin
                hold_asked   = 1'b1;
                hold_request = 1'b1;
            end
            if (!paused && bytes_sent >= 1000)
            begin
                paused = 1'b1;
                drain_results();
            end
        end

        utf8_bus.valid <= 1'b0;
        while (sb.expected_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        sb.finish_check();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_channels.sv
rtl/core/u8u16_core.sv
rtl/core/utf8_to_utf16_validating_decoder.sv
rtl/core/u8u16_checker.sv
dv/utf8_to_utf16_validating_decoder_tb.sv
